@@ hw/rtl/skacc_pkg.sv @@
`default_nettype none
package skacc_pkg;

	localparam int CHANS         = 4;
	localparam int DEFAULT_LANES = 4;

	localparam int TEXEL_W  = 16;
	localparam int WEIGHT_W = 18;
	localparam int PROD_W   = TEXEL_W + 1 + WEIGHT_W - 1;  // 34
	localparam int ROW_W    = 40;
	localparam int TOT_W    = 48;
	localparam int FRAC_BITS = 16;
	localparam int MUL_W    = ROW_W + WEIGHT_W;            // 58
	localparam int P_W      = MUL_W - FRAC_BITS;           // 42
	localparam int SPLIT    = ROW_W / 2;                   // 20

	localparam int CNT_W    = 3;
	localparam int TURN_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUARTER_TURNS = 2'd1;

	localparam logic [CNT_W-1:0]  CHANNEL_COUNT_RST = 3'd4;
	localparam logic [TURN_W-1:0] QUARTER_TURNS_RST = 2'd0;

	typedef enum logic [TURN_W-1:0] {
		TURN_0   = 2'd0,
		TURN_90  = 2'd1,
		TURN_180 = 2'd2,
		TURN_270 = 2'd3
	} turn_t;

	typedef struct packed {
		logic prod_en;
		logic row_en;
		logic mul_en;
		logic fold_en;
		logic row_start;
	} lane_ctl_t;

	typedef struct packed {
		logic en;
		logic row_end;
		logic win_end;
		logic clr;
	} merge_ctl_t;

	function automatic logic signed [ROW_W-1:0] sat_row(input logic signed [ROW_W:0] x);
		logic signed [ROW_W-1:0] r;
		if (x[ROW_W] != x[ROW_W-1])
			r = x[ROW_W] ? {1'b1, {(ROW_W-1){1'b0}}} : {1'b0, {(ROW_W-1){1'b1}}};
		else
			r = x[ROW_W-1:0];
		return r;
	endfunction

	function automatic logic signed [TOT_W-1:0] sat_tot(input logic signed [TOT_W:0] x);
		logic signed [TOT_W-1:0] r;
		if (x[TOT_W] != x[TOT_W-1])
			r = x[TOT_W] ? {1'b1, {(TOT_W-1){1'b0}}} : {1'b0, {(TOT_W-1){1'b1}}};
		else
			r = x[TOT_W-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/skacc_lane.sv @@
`default_nettype none
module skacc_lane
	import skacc_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lane_ctl_t                  ctl,
	input  wire logic                       active,
	input  wire logic        [TEXEL_W-1:0]  texel,
	input  wire logic signed [WEIGHT_W-1:0] uw,
	input  wire logic signed [WEIGHT_W-1:0] vw,
	output logic signed      [P_W-1:0]      p
);

	logic signed [PROD_W-1:0]       prod_q;
	logic signed [ROW_W-1:0]        row_q;
	logic signed [ROW_W-SPLIT+WEIGHT_W-1:0] pp_hi_q;
	logic signed [SPLIT+WEIGHT_W:0] pp_lo_q;
	logic signed [P_W-1:0]          p_q;

	logic signed [ROW_W:0]  row_sum;
	logic signed [MUL_W-1:0] full;

	assign row_sum = {row_q[ROW_W-1], row_q}
		+ {{(ROW_W+1-PROD_W){prod_q[PROD_W-1]}}, prod_q};

	// recombine the two partial products of row sum times row weight
	assign full = {pp_hi_q, {SPLIT{1'b0}}}
		+ {{(MUL_W-SPLIT-WEIGHT_W-1){pp_lo_q[SPLIT+WEIGHT_W]}}, pp_lo_q};

	always_ff @(posedge clk) begin
		if (ctl.prod_en)
			prod_q <= $signed({1'b0, texel}) * uw;
		if (ctl.mul_en) begin
			pp_hi_q <= $signed(row_q[ROW_W-1:SPLIT]) * vw;
			pp_lo_q <= $signed({1'b0, row_q[SPLIT-1:0]}) * vw;
		end
		if (ctl.fold_en)
			p_q <= full[MUL_W-1:FRAC_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctl.row_en && active) begin
			if (ctl.row_start)
				row_q <= {{(ROW_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
			else
				row_q <= sat_row(row_sum);
		end
	end

	assign p = p_q;

endmodule
`default_nettype wire

@@ hw/rtl/skacc_merge.sv @@
`default_nettype none
module skacc_merge
	import skacc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire merge_ctl_t              ctl,
	input  wire logic        [CNT_W-1:0] n_act,
	input  wire turn_t                   turns,
	input  wire logic signed [P_W-1:0]   p [CHANS],
	input  wire logic                    out_stall,
	output logic                         out_valid,
	output logic signed      [TOT_W-1:0] sums [CHANS]
);

	logic signed [TOT_W-1:0] totals_q [CHANS];
	logic signed [TOT_W-1:0] sums_q   [CHANS];
	logic                    out_valid_q;

	logic signed [P_W:0]     pe  [CHANS];
	logic signed [P_W:0]     a   [CHANS];
	logic signed [TOT_W-1:0] nxt [CHANS];
	logic signed [TOT_W-1:0] base;
	logic                    rot;

	assign rot = (n_act >= CNT_W'(2));

	always_comb begin
		for (int c = 0; c < CHANS; c++) begin
			pe[c] = {p[c][P_W-1], p[c]};
			a[c]  = pe[c];
		end
		if (rot) begin
			unique case (turns)
				TURN_90: begin
					a[0] = -pe[1];
					a[1] = pe[0];
				end
				TURN_180: begin
					a[0] = -pe[0];
					a[1] = -pe[1];
				end
				TURN_270: begin
					a[0] = pe[1];
					a[1] = -pe[0];
				end
				default: begin
					a[0] = pe[0];
					a[1] = pe[1];
				end
			endcase
		end
	end

	always_comb begin
		base = '0;
		for (int c = 0; c < CHANS; c++) begin
			base = ctl.clr ? '0 : totals_q[c];
			if (ctl.row_end && (CNT_W'(c) < n_act))
				nxt[c] = sat_tot({base[TOT_W-1], base}
					+ {{(TOT_W-P_W){a[c][P_W]}}, a[c]});
			else
				nxt[c] = base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANS; c++)
				totals_q[c] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.en)
				for (int c = 0; c < CHANS; c++)
					totals_q[c] <= nxt[c];
			if (ctl.en && ctl.win_end)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && ctl.win_end)
			for (int c = 0; c < CHANS; c++)
				sums_q[c] <= (CNT_W'(c) < n_act) ? nxt[c] : '0;
	end

	assign out_valid = out_valid_q;
	assign sums      = sums_q;

endmodule
`default_nettype wire

@@ hw/rtl/separable_kernel_accumulate_top.sv @@
`default_nettype none
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_stall    texel_ch0..3, u_weight, v_weight, flags
// out       source     out_valid / out_stall  sum_ch0..3
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Steps per texel: accept (only when idle), product, row update, split multiply,
// fold and shift, merge into totals. A per-texel sequencer steps the lanes.
// A window-end texel holds in the merge step while the previous result is
// still stalled; other texels pass through regardless of out_stall.
// Reset clears row sums, totals and the output valid; channel_count resets
// to 4 and quarter_turns to 0.
module separable_kernel_accumulate_top
	import skacc_pkg::*;
#(
	parameter int LANES = DEFAULT_LANES
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,

	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic        [TEXEL_W-1:0]   texel_ch0,
	input  wire logic        [TEXEL_W-1:0]   texel_ch1,
	input  wire logic        [TEXEL_W-1:0]   texel_ch2,
	input  wire logic        [TEXEL_W-1:0]   texel_ch3,
	input  wire logic signed [WEIGHT_W-1:0]  u_weight,
	input  wire logic signed [WEIGHT_W-1:0]  v_weight,
	input  wire logic                        row_start,
	input  wire logic                        row_end,
	input  wire logic                        window_end,
	input  wire logic                        clear_total,

	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic signed      [TOT_W-1:0]     sum_ch0,
	output logic signed      [TOT_W-1:0]     sum_ch1,
	output logic signed      [TOT_W-1:0]     sum_ch2,
	output logic signed      [TOT_W-1:0]     sum_ch3,

	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic        [CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [CFG_DATA_W-1:0] cfg_data
);

	localparam int NUM_LANES = (LANES < CHANS) ? LANES : CHANS;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PROD  = 6'b000010,
		ST_ROW   = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_FOLD  = 6'b010000,
		ST_MERGE = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  channel_count_q;
	turn_t             quarter_turns_q;
	logic [CNT_W-1:0]  n_act;

	logic [TEXEL_W-1:0]         texel_q [CHANS];
	logic signed [WEIGHT_W-1:0] uw_q, vw_q;
	logic rs_q, re_q, we_q, clr_q;

	logic       accept;
	logic       merge_go;
	lane_ctl_t  lane_ctl;
	merge_ctl_t merge_ctl;

	logic signed [P_W-1:0]   p   [CHANS];
	logic signed [TOT_W-1:0] sums [CHANS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= CHANNEL_COUNT_RST;
			quarter_turns_q <= turn_t'(QUARTER_TURNS_RST);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_CHANNEL_COUNT)
				channel_count_q <= cfg_data;
			else if (cfg_index == REG_QUARTER_TURNS)
				quarter_turns_q <= turn_t'(cfg_data[TURN_W-1:0]);
		end
	end

	// zero acts as one, anything above the lane count as the lane count
	always_comb begin
		priority if (channel_count_q == '0)
			n_act = CNT_W'(1);
		else if (channel_count_q > CNT_W'(NUM_LANES))
			n_act = CNT_W'(NUM_LANES);
		else
			n_act = channel_count_q;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign merge_go = (state_q == ST_MERGE) && !(we_q && out_valid && out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_PROD;
			ST_PROD:  state_d = ST_ROW;
			ST_ROW:   state_d = ST_MUL;
			ST_MUL:   state_d = ST_FOLD;
			ST_FOLD:  state_d = ST_MERGE;
			ST_MERGE: if (merge_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			texel_q[0] <= texel_ch0;
			texel_q[1] <= texel_ch1;
			texel_q[2] <= texel_ch2;
			texel_q[3] <= texel_ch3;
			uw_q  <= u_weight;
			vw_q  <= v_weight;
			rs_q  <= row_start;
			re_q  <= row_end;
			we_q  <= window_end;
			clr_q <= clear_total;
		end
	end

	assign lane_ctl.prod_en   = (state_q == ST_PROD);
	assign lane_ctl.row_en    = (state_q == ST_ROW);
	assign lane_ctl.mul_en    = (state_q == ST_MUL);
	assign lane_ctl.fold_en   = (state_q == ST_FOLD);
	assign lane_ctl.row_start = rs_q;

	assign merge_ctl.en      = merge_go;
	assign merge_ctl.row_end = re_q;
	assign merge_ctl.win_end = we_q;
	assign merge_ctl.clr     = clr_q;

	for (genvar g = 0; g < CHANS; g++) begin : g_lane
		if (g < NUM_LANES) begin : g_on
			skacc_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (lane_ctl),
				.active (CNT_W'(g) < n_act),
				.texel  (texel_q[g]),
				.uw     (uw_q),
				.vw     (vw_q),
				.p      (p[g])
			);
		end else begin : g_off
			assign p[g] = '0;
		end
	end

	skacc_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (merge_ctl),
		.n_act     (n_act),
		.turns     (quarter_turns_q),
		.p         (p),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.sums      (sums)
	);

	assign sum_ch0 = sums[0];
	assign sum_ch1 = sums[1];
	assign sum_ch2 = sums[2];
	assign sum_ch3 = sums[3];

	a_rise_from_merge: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_MERGE))
		else $error("result raised outside the merge step");

	a_hold_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE && we_q && out_valid && out_stall) |=> state_q == ST_MERGE)
		else $error("window end merged over a stalled result");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_PROD)
		else $error("accepted transaction did not start the sequence");

	a_lane_count: assert property (@(posedge clk) disable iff (!arst_n)
		(n_act >= CNT_W'(1)) && (n_act <= CNT_W'(NUM_LANES)))
		else $error("active channel count out of range");

endmodule
`default_nettype wire
